// File: sv/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants for the tightest range classifier.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int VALUE_W   = 32;
    localparam int IDX_OUT_W = 7;
    localparam int CNT_OUT_W = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    // one stored rule, as held in the rule memory
    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] high;
        logic [VALUE_W-1:0] low;
    } rule_t;

    // scanner control from the sequencer
    typedef struct packed {
        logic init;   // forget the best match, a new lookup starts
        logic vld;    // memory read data is a rule to compare this cycle
    } scan_ctl_t;

endpackage

// File: sv/trc_ram.sv
// ----------------------------------------------------------------------------
// trc_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module trc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/trc_scan.sv
// ----------------------------------------------------------------------------
// trc_scan
// Compares one rule per cycle against the query and keeps the narrowest hit.
// ----------------------------------------------------------------------------
module trc_scan
    import trc_pkg::*;
#(
    parameter int IDX_W = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  logic [IDX_W-1:0]   rule_idx,
    input  rule_t              rule,
    input  logic [VALUE_W-1:0] query_value,
    input  logic               query_kind,
    output logic               best_found,
    output logic [IDX_W-1:0]   best_idx,
    output logic [VALUE_W-1:0] min_span
);

    logic               found_reg, found_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] span_reg, span_next;
    logic [VALUE_W-1:0] span;
    logic               hit;

    always_comb
    begin
        span = rule.high - rule.low;
        hit  = (rule.kind == query_kind) && (query_value >= rule.low)
            && (query_value <= rule.high);

        found_next = found_reg;
        idx_next   = idx_reg;
        span_next  = span_reg;
        if (ctl.init)
        begin
            found_next = 1'b0;
        end
        else if (ctl.vld && hit && (!found_reg || span < span_reg))
        begin
            // strict less-than keeps the earliest rule on a tie
            found_next = 1'b1;
            idx_next   = rule_idx;
            span_next  = span;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        span_reg <= span_next;
    end

    assign best_found = found_reg;
    assign best_idx   = idx_reg;
    assign min_span   = span_reg;

endmodule

// File: sv/tightest_range_classifier_unit.sv
// ----------------------------------------------------------------------------
// tightest_range_classifier_unit
// Rule table of inclusive ranges with narrowest-match lookup.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred when start is high and busy is low. Every
//   command gives one result, shown for exactly one cycle with done high.
//   Clear, append and the unused code return their result in the cycle
//   after the transfer and leave busy low, so they can go every cycle.
//   Append writes the next free slot of the rule memory; a full table
//   drops the rule and sets table_full.
//   Lookup holds busy while it reads the rule memory one entry per cycle
//   through its single read port, then passes through the drain and
//   report states before done rises; on an empty table it answers at
//   once like the other commands and leaves busy low.
//   Reset empties the table at once; the memory itself is not cleared,
//   since only entries below the count are ever read.
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module tightest_range_classifier_unit
    import trc_pkg::*;
#(
    parameter int RULES = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [VALUE_W-1:0]   rule_start,
    input  logic [VALUE_W-1:0]   rule_end,
    input  logic                 rule_kind,
    input  logic [VALUE_W-1:0]   query_value,
    input  logic                 query_kind,
    output logic                 done,
    output logic                 found,
    output logic [IDX_OUT_W-1:0] match_index,
    output logic [VALUE_W-1:0]   match_span,
    output logic                 table_full,
    output logic [CNT_OUT_W-1:0] entry_count
);

    localparam int IDX_W  = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CNT_W  = $clog2(RULES + 1);
    localparam int RULE_W = $bits(rule_t);
    localparam logic [CNT_W-1:0] RULES_C = CNT_W'(RULES);

    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_OUT_W-1:0] w;
        w = {{CNT_OUT_W{1'b0}}, c};
        return w[CNT_OUT_W-1:0];
    endfunction

    function automatic logic [IDX_OUT_W-1:0] idx_out(input logic [IDX_W-1:0] i);
        logic [IDX_W+IDX_OUT_W-1:0] w;
        w = {{IDX_OUT_W{1'b0}}, i};
        return w[IDX_OUT_W-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [VALUE_W-1:0]   qval_reg, qval_next;
    logic                 qkind_reg, qkind_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [IDX_OUT_W-1:0] idx_reg, idx_next;
    logic [VALUE_W-1:0]   span_reg, span_next;
    logic                 full_reg, full_next;
    logic [CNT_OUT_W-1:0] ecount_reg, ecount_next;

    logic                 wr_en;
    logic                 rd_en;
    rule_t                wr_rule;
    logic [RULE_W-1:0]    rd_data;
    rule_t                rd_rule;
    scan_ctl_t            ctl;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic [VALUE_W-1:0]   min_span;

    assign wr_rule = '{kind: rule_kind, high: rule_end, low: rule_start};
    assign rd_rule = rule_t'(rd_data);

    trc_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULES),
        .AW    (IDX_W)
    ) u_rules (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_rule),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    trc_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .rule_idx    (pend_idx_reg),
        .rule        (rd_rule),
        .query_value (qval_reg),
        .query_kind  (qkind_reg),
        .best_found  (best_found),
        .best_idx    (best_idx),
        .min_span    (min_span)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        qval_next     = qval_reg;
        qkind_next    = qkind_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        idx_next      = idx_reg;
        span_next     = span_reg;
        full_next     = full_reg;
        ecount_next   = ecount_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        ctl.init      = 1'b0;
        ctl.vld       = pend_vld_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // non-lookup results default to no match
                    found_next  = 1'b0;
                    idx_next    = '0;
                    span_next   = '0;
                    full_next   = 1'b0;
                    ecount_next = cnt_out(count_reg);
                    done_next   = 1'b1;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            ecount_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == RULES_C)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                ecount_next = cnt_out(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            qval_next  = query_value;
                            qkind_next = query_kind;
                            ctl.init   = 1'b1;
                            scan_next  = '0;
                            if (count_reg != '0)
                            begin
                                done_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                pend_vld_next = 1'b1;
                pend_idx_next = scan_reg[IDX_W-1:0];
                scan_next     = scan_reg + CNT_W'(1);
                if (scan_reg == count_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last rule is compared this cycle
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                done_next   = 1'b1;
                found_next  = best_found;
                idx_next    = best_found ? idx_out(best_idx) : '0;
                span_next   = best_found ? min_span : '0;
                full_next   = 1'b0;
                ecount_next = cnt_out(count_reg);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            pend_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            pend_vld_reg <= pend_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        qval_reg     <= qval_next;
        qkind_reg    <= qkind_next;
        found_reg    <= found_next;
        idx_reg      <= idx_next;
        span_reg     <= span_next;
        full_reg     <= full_next;
        ecount_reg   <= ecount_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign match_index = idx_reg;
    assign match_span  = span_reg;
    assign table_full  = full_reg;
    assign entry_count = ecount_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RULES_C)
        else $error("rule count above table depth");

    a_scan_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("scan left without drain");

    a_pend_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (CNT_W'(pend_idx_reg) < count_reg))
        else $error("compared a rule beyond the count");

    a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && full_reg))
        else $error("match and full flagged together");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE && !rd_en && !pend_vld_reg))
        else $error("rule write during a scan");

endmodule

// File: tb/sv/tb_tightest_range_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tightest_range_classifier_unit
// Self-checking bench for the narrowest-range rule table.
// A short table of directed commands comes first: empty-table lookups,
// unused codes, full-width, point and inverted rules, equal-span ties.
// Random episodes of clear/append/lookup follow, some filling the table past
// capacity. Every transfer is predicted here and each done strobe is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tightest_range_classifier_unit;
    import trc_pkg::*;

    localparam int NUM_RULES = 128;
    localparam int ITEM_GOAL = 1450;
    localparam int DIR_ROWS  = 20;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [VALUE_W-1:0] rs;
        logic [VALUE_W-1:0] re;
        logic               rk;
        logic [VALUE_W-1:0] qv;
        logic               qk;
    } cmd_item_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] idx;
        logic [VALUE_W-1:0]   span;
        logic                 full;
        logic [CNT_OUT_W-1:0] count;
    } outcome_t;

    // directed row: command fields, then a typed-in outcome when lit is set
    typedef struct packed {
        logic [1:0]           cmd;
        logic [VALUE_W-1:0]   rs;
        logic [VALUE_W-1:0]   re;
        logic                 rk;
        logic [VALUE_W-1:0]   qv;
        logic                 qk;
        logic                 lit;
        logic                 e_found;
        logic [IDX_OUT_W-1:0] e_idx;
        logic [VALUE_W-1:0]   e_span;
        logic                 e_full;
        logic [CNT_OUT_W-1:0] e_count;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           command = 2'd0;
    logic [VALUE_W-1:0]   rule_start = '0;
    logic [VALUE_W-1:0]   rule_end = '0;
    logic                 rule_kind = 1'b0;
    logic [VALUE_W-1:0]   query_value = '0;
    logic                 query_kind = 1'b0;
    logic                 busy;
    logic                 done;
    logic                 found;
    logic [IDX_OUT_W-1:0] match_index;
    logic [VALUE_W-1:0]   match_span;
    logic                 table_full;
    logic [CNT_OUT_W-1:0] entry_count;

    // predictor copy of the rule table
    logic [VALUE_W-1:0] tbl_lo   [NUM_RULES];
    logic [VALUE_W-1:0] tbl_hi   [NUM_RULES];
    logic               tbl_kind [NUM_RULES];
    int                 tbl_held = 0;

    outcome_t outcomes_due [$];
    int       bad_fields = 0;
    int       items_sent = 0;
    bit       idle_en = 1'b1;

    dir_row_t dir_table [DIR_ROWS];

    tightest_range_classifier_unit #(.RULES(NUM_RULES)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .rule_start  (rule_start),
        .rule_end    (rule_end),
        .rule_kind   (rule_kind),
        .query_value (query_value),
        .query_kind  (query_kind),
        .done        (done),
        .found       (found),
        .match_index (match_index),
        .match_span  (match_span),
        .table_full  (table_full),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    function automatic outcome_t classify_item(cmd_item_t it);
        outcome_t           r;
        logic [VALUE_W-1:0] span;
        r = '0;
        case (it.cmd)
            CMD_CLEAR:
            begin
                tbl_held = 0;
            end
            CMD_APPEND:
            begin
                if (tbl_held >= NUM_RULES)
                begin
                    r.full = 1'b1;
                end
                else
                begin
                    tbl_lo[tbl_held]   = it.rs;
                    tbl_hi[tbl_held]   = it.re;
                    tbl_kind[tbl_held] = it.rk;
                    tbl_held++;
                end
            end
            CMD_LOOKUP:
            begin
                for (int i = 0; i < tbl_held; i++)
                begin
                    if (tbl_kind[i] == it.qk && it.qv >= tbl_lo[i] && it.qv <= tbl_hi[i])
                    begin
                        span = tbl_hi[i] - tbl_lo[i];
                        // strict compare keeps the earliest rule on a tie
                        if (!r.found || span < r.span)
                        begin
                            r.found = 1'b1;
                            r.idx   = i[IDX_OUT_W-1:0];
                            r.span  = span;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = tbl_held[CNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return VALUE_W'($urandom_range(0, 200));
            5:       return '1 - VALUE_W'($urandom_range(0, 200));
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_item_t rand_rule_item();
        cmd_item_t it;
        it.cmd = CMD_APPEND;
        it.rs  = rand_value();
        case ($urandom_range(0, 7))
            0:       it.re = it.rs;
            1:       it.re = rand_value();
            2:
            begin
                it.rs = '0;
                it.re = '1;
            end
            // may wrap past the top and give an inverted rule
            default: it.re = it.rs + VALUE_W'($urandom_range(0, 48));
        endcase
        it.rk = 1'($urandom_range(0, 1));
        it.qv = $urandom;
        it.qk = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic cmd_item_t rand_lookup_item();
        cmd_item_t          it;
        int                 pick;
        logic [VALUE_W-1:0] span;
        it.cmd = CMD_LOOKUP;
        it.rs  = $urandom;
        it.re  = $urandom;
        it.rk  = 1'($urandom_range(0, 1));
        it.qv  = rand_value();
        it.qk  = 1'($urandom_range(0, 1));
        // mostly aim inside a stored rule so matches and ties are common
        if (tbl_held > 0 && $urandom_range(0, 9) < 7)
        begin
            pick = $urandom_range(0, tbl_held - 1);
            if ($urandom_range(0, 3) != 0)
                it.qk = tbl_kind[pick];
            if (tbl_lo[pick] <= tbl_hi[pick])
            begin
                span = tbl_hi[pick] - tbl_lo[pick];
                case ($urandom_range(0, 3))
                    0:       it.qv = tbl_lo[pick];
                    1:       it.qv = tbl_hi[pick];
                    default:
                    begin
                        if (span == '1)
                            it.qv = $urandom;
                        else
                            it.qv = tbl_lo[pick] + ($urandom % (span + 1));
                    end
                endcase
            end
        end
        return it;
    endfunction

    function automatic cmd_item_t rand_noise_item();
        cmd_item_t it;
        it.cmd = 2'($urandom_range(0, 3));
        it.rs  = $urandom;
        it.re  = $urandom;
        it.rk  = 1'($urandom_range(0, 1));
        it.qv  = $urandom;
        it.qk  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // one command transfer; the outcome is queued at the accepting edge
    task automatic send(input cmd_item_t it, input bit lit, input outcome_t lit_out,
                        input bit drain_first);
        outcome_t predicted;
        if (drain_first || (idle_en && $urandom_range(0, 99) < 12))
        begin
            start <= 1'b0;
            if (drain_first)
            begin
                do @(posedge clk); while (outcomes_due.size() != 0);
            end
            else
            begin
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        start       <= 1'b1;
        command     <= it.cmd;
        rule_start  <= it.rs;
        rule_end    <= it.re;
        rule_kind   <= it.rk;
        query_value <= it.qv;
        query_kind  <= it.qk;
        do @(posedge clk); while (busy !== 1'b0);
        predicted = classify_item(it);
        outcomes_due.push_back(lit ? lit_out : predicted);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
            bad_fields++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done === 1'b1)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: done expected low, got high (no transfer pending)", $time);
                bad_fields++;
            end
            else
            begin
                e = outcomes_due.pop_front();
                check_field("found", VALUE_W'(e.found), VALUE_W'(found));
                check_field("match_index", VALUE_W'(e.idx), VALUE_W'(match_index));
                check_field("match_span", e.span, match_span);
                check_field("table_full", VALUE_W'(e.full), VALUE_W'(table_full));
                check_field("entry_count", VALUE_W'(e.count), VALUE_W'(entry_count));
            end
        end
    end

    initial
    begin
        cmd_item_t it;
        outcome_t  lit_out;
        int        n;
        int        ep;

        dir_table = '{
            // empty table after reset, unused code, clear on empty
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_UNUSED, '1, '1, 1'b1, '1, 1'b1, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_CLEAR, '1, '1, 1'b1, '1, 1'b1, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            // full-width, plain, point, inverted and a duplicate for the tie
            '{CMD_APPEND, 32'h0, '1, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd1},
            '{CMD_APPEND, 32'd10, 32'd20, 1'b0, '1, 1'b1, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd2},
            '{CMD_APPEND, 32'd15, 32'd15, 1'b1, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd3},
            '{CMD_APPEND, 32'd100, 32'd50, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd4},
            '{CMD_APPEND, 32'd10, 32'd20, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd5},
            '{CMD_LOOKUP, '1, '1, 1'b1, 32'd15, 1'b0, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'd15, 1'b1, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'd75, 1'b0, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, '1, 1'b0, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'd100, 1'b0, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_UNUSED, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b1, 32'h0f0f0f0f, 1'b0, 1'b0,
              1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_APPEND, '1, '1, 1'b1, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd6},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, '1, 1'b1, 1'b0, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_LOOKUP, 32'h0, 32'h0, 1'b0, 32'd15, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0},
            '{CMD_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 7'd0, 32'h0, 1'b0, 8'd0}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it      = '{dir_table[i].cmd, dir_table[i].rs, dir_table[i].re, dir_table[i].rk,
                        dir_table[i].qv, dir_table[i].qk};
            lit_out = '{dir_table[i].e_found, dir_table[i].e_idx, dir_table[i].e_span,
                        dir_table[i].e_full, dir_table[i].e_count};
            send(it, dir_table[i].lit, lit_out, 1'b0);
        end

        // fill past capacity, then scan the full table
        for (int i = 0; i < NUM_RULES + 2; i++)
            send(rand_rule_item(), 1'b0, '0, i == 0);
        for (int i = 0; i < 4; i++)
            send(rand_lookup_item(), 1'b0, '0, 1'b0);

        while (items_sent < ITEM_GOAL)
        begin
            idle_en = !(items_sent >= 500 && items_sent < 800);
            ep = $urandom_range(0, 99);
            if (ep < 8)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send(rand_noise_item(), 1'b0, '0, 1'b0);
            end
            else if (ep < 11)
            begin
                n = NUM_RULES - tbl_held + $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send(rand_rule_item(), 1'b0, '0, 1'b0);
                for (int i = 0; i < 4; i++)
                    send(rand_lookup_item(), 1'b0, '0, 1'b0);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    it     = rand_noise_item();
                    it.cmd = CMD_CLEAR;
                    send(it, 1'b0, '0, $urandom_range(0, 19) == 0);
                end
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send(rand_rule_item(), 1'b0, '0, 1'b0);
                n = $urandom_range(2, 10);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 5) == 0)
                        send(rand_rule_item(), 1'b0, '0, 1'b0);
                    send(rand_lookup_item(), 1'b0, '0, 1'b0);
                end
            end
        end

        start <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
        if (bad_fields == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
